@@ rtl/core/bheq_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Button history edge query package
// Field widths, defaults, operation and register codes, sequencer states.
// -----------------------------------------------------------------------------
package bheq_pkg;

   // Defaults for the top level parameters
   localparam int DEF_MAX_DEPTH   = 4096;
   localparam int DEF_MAX_BUTTONS = 16;
   localparam int DEF_MAX_WINDOW  = 255;

   // Field widths
   localparam int OP_W    = 2;
   localparam int MASK_W  = 16;
   localparam int BTN_W   = 4;
   localparam int FRAME_W = 32;
   localparam int WIN_W   = 8;

   // Register widths and reset values
   localparam int RING_DEPTH_W  = 13;
   localparam int ACT_BTN_W     = 5;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 13;
   localparam logic [RING_DEPTH_W-1:0] RESET_RING_DEPTH     = 13'd4096;
   localparam logic [ACT_BTN_W-1:0]    RESET_ACTIVE_BUTTONS = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH     = 2'd0,
      OP_PRESSED  = 2'd1,
      OP_RELEASED = 2'd2,
      OP_CONSUME  = 2'd3
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RING_DEPTH     = 2'd0,
      CSR_ACTIVE_BUTTONS = 2'd1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_MOD   = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

@@ rtl/core/bheq_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Button history edge query channels
// Request, response and register write channels with valid/ready handshake.
// -----------------------------------------------------------------------------
interface bheq_req_if import bheq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   op_type               op;
   logic [MASK_W-1:0]    pressed_mask;
   logic [BTN_W-1:0]     button;
   logic [FRAME_W-1:0]   frame_number;
   logic [WIN_W-1:0]     window;

   modport source (output valid, op, pressed_mask, button, frame_number, window,
                   input ready);
   modport sink   (input valid, op, pressed_mask, button, frame_number, window,
                   output ready);
endinterface

interface bheq_rsp_if import bheq_pkg::*; ();
   logic valid;
   logic ready;
   logic answer;
   logic history_wrapped;

   modport source (output valid, answer, history_wrapped, input ready);
   modport sink   (input valid, answer, history_wrapped, output ready);
endinterface

interface bheq_csr_if import bheq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

@@ rtl/core/button_history_edge_query_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Button history edge query core
// Frame bitmap ring, push counter, consume barriers and edge queries.
// -----------------------------------------------------------------------------
// After reset the core sweeps the history memory to zero, one slot a cycle;
// no request is taken during that sweep (register writes are). Each
// request then runs on its own. A consume passes through the done state
// into the output register. A push runs a bit-serial remainder unit that
// reduces the frame count by the ring depth, one dividend bit per cycle,
// and writes the bitmap on the last remainder step. A query runs the same
// remainder on its frame number, then scans the ring backward through the
// single read port of the history memory, one slot per cycle behind a
// registered read, covering the queried slot and up to w older slots,
// where w is the window clamped to MAX_WINDOW and the ring depth. The
// result waits in an output register, so the next request can be taken
// while a result is still pending.
// -----------------------------------------------------------------------------
module button_history_edge_query_core
   import bheq_pkg::*;
#(
   parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
   parameter int MAX_BUTTONS = DEF_MAX_BUTTONS,
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW
) (
   input  logic        clock,
   input  logic        reset,
   bheq_req_if.sink    req_bus,
   bheq_rsp_if.source  rsp_bus,
   bheq_csr_if.sink    csr_bus
);

   // Width of an effective depth value and of a slot index
   localparam int DW        = $clog2(MAX_DEPTH + 1);
   localparam int SW        = $clog2(MAX_DEPTH);
   localparam int BW        = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
   localparam int BTN_EXT_W = 7;
   localparam int MCNT_W    = $clog2(FRAME_W);
   localparam logic [MCNT_W-1:0] MOD_LAST  = MCNT_W'(FRAME_W - 1);
   localparam logic [SW-1:0]     CLR_LAST  = SW'(MAX_DEPTH - 1);

   // ---------------------------------------------------------------- state
   state_type              state_ff, state_in;
   logic [SW-1:0]          clr_addr_ff, clr_addr_in;
   logic [FRAME_W-1:0]     count_ff, count_in;
   logic [RING_DEPTH_W-1:0] depth_cfg_ff, depth_cfg_in;
   logic [ACT_BTN_W-1:0]   btns_cfg_ff, btns_cfg_in;
   logic [FRAME_W-1:0]     barrier_ff [MAX_BUTTONS];
   logic [FRAME_W-1:0]     barrier_in [MAX_BUTTONS];
   logic                   rsp_valid_ff, rsp_valid_in;

   // Working registers of the current request
   op_type                 op_ff, op_in;
   logic [MASK_W-1:0]      mask_ff, mask_in;
   logic [BTN_W-1:0]       btn_ff, btn_in;
   logic [FRAME_W-1:0]     frame_ff, frame_in;
   logic [WIN_W-1:0]       win_ff, win_in;
   logic [FRAME_W-1:0]     bar_sel_ff, bar_sel_in;
   logic [FRAME_W-1:0]     div_ff, div_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [MCNT_W-1:0]      mod_cnt_ff, mod_cnt_in;
   logic [SW-1:0]          addr_ff, addr_in;
   logic                   pipe_ff, pipe_in;
   logic [WIN_W-1:0]       step_ff, step_in;
   logic [FRAME_W-1:0]     probe_ff, probe_in;
   logic                   ans_ff, ans_in;
   logic                   rsp_answer_ff, rsp_answer_in;
   logic                   rsp_wrapped_ff, rsp_wrapped_in;

   // History memory
   logic [MASK_W-1:0]      hist_mem [MAX_DEPTH];
   logic [MASK_W-1:0]      rd_data_ff;
   logic                   wr_en;
   logic [SW-1:0]          wr_addr;
   logic [MASK_W-1:0]      wr_data;

   // ---------------------------------------------------- derived settings
   logic [FRAME_W-1:0]     depth32;
   logic [DW-1:0]          eff_d;
   logic [FRAME_W-1:0]     btns32;
   logic [MASK_W-1:0]      keep_mask;
   logic [FRAME_W-1:0]     win32;
   logic [BTN_EXT_W-1:0]   req_btn_ext;
   logic                   req_btn_ok;
   logic                   req_accept;
   logic                   rsp_free;

   // Clamp ring depth to 1..MAX_DEPTH
   always_comb begin
      depth32 = 32'(depth_cfg_ff);
      if (depth32 == 32'd0) begin
         depth32 = 32'd1;
      end
      if (depth32 > 32'(MAX_DEPTH)) begin
         depth32 = 32'(MAX_DEPTH);
      end
      eff_d = DW'(depth32);
   end

   // Clamp active buttons and build the keep mask
   always_comb begin
      btns32 = 32'(btns_cfg_ff);
      if (btns32 == 32'd0) begin
         btns32 = 32'd1;
      end
      if (btns32 > 32'(MAX_BUTTONS)) begin
         btns32 = 32'(MAX_BUTTONS);
      end
      for (int j = 0; j < MASK_W; j++) begin
         keep_mask[j] = (32'(j) < btns32);
      end
   end

   // Clamp the requested window to MAX_WINDOW and the depth
   always_comb begin
      win32 = 32'(req_bus.window);
      if (win32 > 32'(MAX_WINDOW)) begin
         win32 = 32'(MAX_WINDOW);
      end
      if (win32 > 32'(eff_d)) begin
         win32 = 32'(eff_d);
      end
   end

   assign req_btn_ext = BTN_EXT_W'(req_bus.button);
   assign req_btn_ok  = (32'(req_bus.button) < 32'(MAX_BUTTONS));

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   assign csr_bus.ready = 1'b1;

   // ---------------------------------------------------- remainder unit
   // One restoring step per cycle: shift in the next dividend bit and
   // subtract the depth when the partial remainder reaches it.
   logic [DW:0]            rem_shift;
   logic [DW:0]            rem_red;
   logic [DW-1:0]          rem_next;
   logic                   mod_last;

   assign rem_shift = {rem_ff, div_ff[FRAME_W-1]};
   assign rem_red   = (rem_shift >= {1'b0, eff_d}) ? (rem_shift - {1'b0, eff_d}) : rem_shift;
   assign rem_next  = rem_red[DW-1:0];
   assign mod_last  = (mod_cnt_ff == MOD_LAST);

   // ---------------------------------------------------------- scan check
   logic                   want_held;
   logic                   held;
   logic                   mismatch;
   logic                   scan_done;
   logic                   scan_ans;
   logic [SW-1:0]          prev_slot;

   assign want_held = (op_ff == OP_PRESSED);
   assign held      = rd_data_ff[btn_ff];
   assign mismatch  = (held != want_held);
   assign prev_slot = (addr_ff == '0) ? SW'(eff_d - DW'(1)) : (addr_ff - SW'(1));

   // Data in rd_data_ff belongs to back step step_ff; step zero is the
   // queried frame itself, later steps also face the consume barrier.
   always_comb begin
      scan_done = 1'b0;
      scan_ans  = 1'b0;
      if (pipe_ff) begin
         if (step_ff == '0) begin
            if (mismatch) begin
               scan_done = 1'b1;
            end
         end else if (probe_ff < bar_sel_ff) begin
            scan_done = 1'b1;
         end else if (mismatch) begin
            scan_done = 1'b1;
            scan_ans  = 1'b1;
         end
         if (!scan_done && (step_ff == win_ff)) begin
            scan_done = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------- sequencer
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      count_in       = count_ff;
      depth_cfg_in   = depth_cfg_ff;
      btns_cfg_in    = btns_cfg_ff;
      barrier_in     = barrier_ff;
      rsp_valid_in   = rsp_valid_ff;
      op_in          = op_ff;
      mask_in        = mask_ff;
      btn_in         = btn_ff;
      frame_in       = frame_ff;
      win_in         = win_ff;
      bar_sel_in     = bar_sel_ff;
      div_in         = div_ff;
      rem_in         = rem_ff;
      mod_cnt_in     = mod_cnt_ff;
      addr_in        = addr_ff;
      pipe_in        = pipe_ff;
      step_in        = step_ff;
      probe_in       = probe_ff;
      ans_in         = ans_ff;
      rsp_answer_in  = rsp_answer_ff;
      rsp_wrapped_in = rsp_wrapped_ff;
      wr_en          = 1'b0;
      wr_addr        = clr_addr_ff;
      wr_data        = '0;

      // Register writes
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_RING_DEPTH:     depth_cfg_in = csr_bus.wdata[RING_DEPTH_W-1:0];
            CSR_ACTIVE_BUTTONS: btns_cfg_in  = csr_bus.wdata[ACT_BTN_W-1:0];
            default: ;
         endcase
      end

      // Drop the response once it has been taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + SW'(1);
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               op_in      = req_bus.op;
               mask_in    = req_bus.pressed_mask & keep_mask;
               btn_in     = req_bus.button;
               frame_in   = req_bus.frame_number;
               win_in     = WIN_W'(win32);
               bar_sel_in = barrier_ff[req_btn_ext[BW-1:0]];
               rem_in     = '0;
               mod_cnt_in = '0;
               ans_in     = 1'b0;
               case (req_bus.op)
                  OP_PUSH: begin
                     div_in   = count_ff;
                     state_in = ST_MOD;
                  end
                  OP_PRESSED, OP_RELEASED: begin
                     div_in = req_bus.frame_number;
                     // A button beyond storage answers zero at once
                     state_in = req_btn_ok ? ST_MOD : ST_DONE;
                  end
                  OP_CONSUME: begin
                     if (req_btn_ok) begin
                        barrier_in[req_btn_ext[BW-1:0]] = req_bus.frame_number;
                     end
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         ST_MOD: begin
            rem_in     = rem_next;
            div_in     = {div_ff[FRAME_W-2:0], 1'b0};
            mod_cnt_in = mod_cnt_ff + MCNT_W'(1);
            if (mod_last) begin
               if (op_ff == OP_PUSH) begin
                  wr_en    = 1'b1;
                  wr_addr  = rem_next[SW-1:0];
                  wr_data  = mask_ff;
                  count_in = count_ff + FRAME_W'(1);
                  state_in = ST_DONE;
               end else begin
                  addr_in  = rem_next[SW-1:0];
                  pipe_in  = 1'b0;
                  step_in  = '0;
                  probe_in = frame_ff;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (scan_done) begin
               ans_in   = scan_ans;
               state_in = ST_DONE;
            end else begin
               // Issue the next older slot while checking the current one
               addr_in = prev_slot;
               pipe_in = 1'b1;
               if (pipe_ff) begin
                  step_in  = step_ff + WIN_W'(1);
                  probe_in = probe_ff - FRAME_W'(1);
               end
            end
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_answer_in  = ans_ff;
               rsp_wrapped_in = (count_ff >= FRAME_W'(eff_d));
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         depth_cfg_ff <= RESET_RING_DEPTH;
         btns_cfg_ff  <= RESET_ACTIVE_BUTTONS;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_BUTTONS; k++) begin
            barrier_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         depth_cfg_ff <= depth_cfg_in;
         btns_cfg_ff  <= btns_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         barrier_ff   <= barrier_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      mask_ff        <= mask_in;
      btn_ff         <= btn_in;
      frame_ff       <= frame_in;
      win_ff         <= win_in;
      bar_sel_ff     <= bar_sel_in;
      div_ff         <= div_in;
      rem_ff         <= rem_in;
      mod_cnt_ff     <= mod_cnt_in;
      addr_ff        <= addr_in;
      pipe_ff        <= pipe_in;
      step_ff        <= step_in;
      probe_ff       <= probe_in;
      ans_ff         <= ans_in;
      rsp_answer_ff  <= rsp_answer_in;
      rsp_wrapped_ff <= rsp_wrapped_in;
   end

   // History memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= hist_mem[addr_ff];
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.answer          = rsp_answer_ff;
   assign rsp_bus.history_wrapped = rsp_wrapped_ff;

   // ----------------------------------------------------------- assertions
   a_rem_below_depth : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) |-> (32'(rem_ff) < 32'(eff_d)))
      else $error("remainder reached the ring depth");

   a_scan_slot_in_ring : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(addr_ff) < 32'(eff_d)))
      else $error("scan slot outside the ring");

   a_step_within_window : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && pipe_ff) |-> (step_ff <= win_ff))
      else $error("scan ran past the window");

   a_count_only_on_push : assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         $past(state_ff == ST_MOD && mod_last && op_ff == OP_PUSH))
      else $error("frame count moved without a push");

endmodule
